FILE: rtl/ttd_pkg.sv
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants for the time-tag record decoder.
// ----------------------------------------------------------------------------
package ttd_pkg;

    localparam int RecordWidth   = 32;
    localparam int FormatWidth   = 3;
    localparam int ChannelWidth  = 7;
    localparam int TimeWidth     = 64;
    localparam int DelayWidth    = 15;
    localparam int MarkerWidth   = 12;
    localparam int CountWidth    = 25;
    localparam int ApbDataWidth  = 32;
    localparam int ApbAddrWidth  = 3;

    // record_format codes
    localparam logic [FormatWidth-1:0] FMT_NARROW_T2  = 3'd0;
    localparam logic [FormatWidth-1:0] FMT_NARROW_T3  = 3'd1;
    localparam logic [FormatWidth-1:0] FMT_WIDE_T2_V1 = 3'd2;
    localparam logic [FormatWidth-1:0] FMT_WIDE_T2_V2 = 3'd3;
    localparam logic [FormatWidth-1:0] FMT_WIDE_T3_V1 = 3'd4;
    localparam logic [FormatWidth-1:0] FMT_WIDE_T3_V2 = 3'd5;

    // register index of record_format
    localparam logic REG_RECORD_FORMAT = 1'b0;

    // wrap constants
    localparam logic [TimeWidth-1:0] NARROW_T3_WRAP  = 64'd65536;
    localparam logic [TimeWidth-1:0] NARROW_T2_WRAP  = 64'd210698240;
    localparam logic [TimeWidth-1:0] WIDE_T2_WRAP_V1 = 64'd33552000;
    localparam int                   WIDE_T2_V2_SHIFT = 25;   // wrap of 33554432
    localparam int                   WIDE_T3_SHIFT    = 10;   // wrap of 1024

    localparam logic [5:0] WIDE_SPECIAL_OVERFLOW = 6'h3F;
    localparam logic [3:0] NARROW_SPECIAL        = 4'hF;

    typedef enum logic [1:0] {
        KIND_PHOTON   = 2'd0,
        KIND_MARKER   = 2'd1,
        KIND_OVERFLOW = 2'd2,
        KIND_IGNORED  = 2'd3
    } t_event_kind;

    typedef struct packed {
        t_event_kind              kind;
        logic [ChannelWidth-1:0]  channel;
        logic [TimeWidth-1:0]     time_val;
        logic [DelayWidth-1:0]    delay;
        logic [MarkerWidth-1:0]   marker;
        logic [CountWidth-1:0]    count;
        logic                     illegal;
    } t_result;

    typedef struct packed {
        logic                  en;
        logic [TimeWidth-1:0]  addend;
    } t_base_update;

endpackage

FILE: rtl/ttd_apb_regs.sv
// ----------------------------------------------------------------------------
// ttd_apb_regs
// APB register file holding the record format selection.
// ----------------------------------------------------------------------------
module ttd_apb_regs import ttd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ApbAddrWidth-1:0]  paddr,
    input  logic [ApbDataWidth-1:0]  pwdata,
    output logic [ApbDataWidth-1:0]  prdata,
    output logic                     pready,
    output logic [FormatWidth-1:0]   o_record_format
);

    logic [FormatWidth-1:0] r_format;
    logic [FormatWidth-1:0] n_format;
    logic                   sel_format;

    assign sel_format = (paddr[2] == REG_RECORD_FORMAT);
    assign pready     = 1'b1;

    always_comb begin
        n_format = r_format;
        if (psel && penable && pwrite && sel_format) begin
            n_format = pwdata[FormatWidth-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_NARROW_T2;
        end else begin
            r_format <= n_format;
        end
    end

    assign prdata = sel_format ? {{(ApbDataWidth-FormatWidth){1'b0}}, r_format}
                               : '0;
    assign o_record_format = r_format;

endmodule

FILE: rtl/ttd_record_decode.sv
// ----------------------------------------------------------------------------
// ttd_record_decode
// Decodes one record word against the current overflow base.
// ----------------------------------------------------------------------------
module ttd_record_decode import ttd_pkg::*; (
    input  logic [RecordWidth-1:0]  i_word,
    input  logic [FormatWidth-1:0]  i_format,
    input  logic [TimeWidth-1:0]    i_base,
    output t_result                 o_result,
    output t_base_update            o_update
);

    logic [3:0]            narrow_chan;
    logic [5:0]            w_chan;
    logic                  w_special;
    logic [24:0]           w_tag;
    logic [9:0]            w_nsync;
    logic [24:0]           tag_count;
    logic [9:0]            nsync_count;
    logic [27:0]           time_offset;
    logic [TimeWidth-1:0]  time_sum;
    t_result               res;
    t_base_update          upd;

    assign narrow_chan = i_word[31:28];
    assign w_special   = i_word[31];
    assign w_chan      = i_word[30:25];
    assign w_tag       = i_word[24:0];
    assign w_nsync     = i_word[9:0];

    // version 2 overflow with a zero count still means one wrap
    assign tag_count   = (w_tag == '0)   ? 25'd1 : w_tag;
    assign nsync_count = (w_nsync == '0) ? 10'd1 : w_nsync;

    always_comb begin
        unique case (i_format)
            FMT_NARROW_T2:                  time_offset = i_word[27:0];
            FMT_NARROW_T3:                  time_offset = {12'b0, i_word[15:0]};
            FMT_WIDE_T2_V1, FMT_WIDE_T2_V2: time_offset = {3'b0, w_tag};
            default:                        time_offset = {18'b0, w_nsync};
        endcase
    end

    assign time_sum = i_base + {{(TimeWidth-28){1'b0}}, time_offset};

    always_comb begin
        res        = '0;
        res.kind   = KIND_IGNORED;
        upd        = '0;
        unique case (i_format)
            FMT_NARROW_T2: begin
                priority if (narrow_chan == NARROW_SPECIAL) begin
                    if (i_word[3:0] == 4'h0) begin
                        res.kind   = KIND_OVERFLOW;
                        res.count  = 25'd1;
                        upd.en     = 1'b1;
                        upd.addend = NARROW_T2_WRAP;
                    end else begin
                        res.kind     = KIND_MARKER;
                        res.time_val = time_sum;
                        res.marker   = {8'b0, i_word[3:0]};
                    end
                end else if (narrow_chan > 4'd4) begin
                    res.illegal = 1'b1;
                end else begin
                    res.kind     = KIND_PHOTON;
                    res.channel  = {3'b0, narrow_chan};
                    res.time_val = time_sum;
                end
            end
            FMT_NARROW_T3: begin
                if (narrow_chan == NARROW_SPECIAL) begin
                    if (i_word[27:16] == 12'h0) begin
                        res.kind   = KIND_OVERFLOW;
                        res.count  = 25'd1;
                        upd.en     = 1'b1;
                        upd.addend = NARROW_T3_WRAP;
                    end else begin
                        res.kind     = KIND_MARKER;
                        res.time_val = time_sum;
                        res.marker   = i_word[27:16];
                    end
                end else begin
                    res.kind     = KIND_PHOTON;
                    res.channel  = {3'b0, narrow_chan};
                    res.time_val = time_sum;
                    res.delay    = {3'b0, i_word[27:16]};
                    res.illegal  = (narrow_chan == 4'd0) || (narrow_chan > 4'd4);
                end
            end
            FMT_WIDE_T2_V1, FMT_WIDE_T2_V2: begin
                priority if (!w_special) begin
                    res.kind     = KIND_PHOTON;
                    res.channel  = {1'b0, w_chan} + 7'd1;
                    res.time_val = time_sum;
                end else if (w_chan == WIDE_SPECIAL_OVERFLOW) begin
                    res.kind = KIND_OVERFLOW;
                    upd.en   = 1'b1;
                    if (i_format == FMT_WIDE_T2_V1) begin
                        res.count  = 25'd1;
                        upd.addend = WIDE_T2_WRAP_V1;
                    end else begin
                        res.count  = tag_count;
                        upd.addend = {{(TimeWidth-CountWidth){1'b0}}, tag_count}
                                     << WIDE_T2_V2_SHIFT;
                    end
                end else if (w_chan == 6'd0) begin
                    res.kind     = KIND_PHOTON;
                    res.time_val = time_sum;
                end else if (w_chan <= 6'd15) begin
                    res.kind     = KIND_MARKER;
                    res.time_val = time_sum;
                    res.marker   = {6'b0, w_chan};
                end else begin
                    res.kind = KIND_IGNORED;
                end
            end
            FMT_WIDE_T3_V1, FMT_WIDE_T3_V2: begin
                priority if (!w_special) begin
                    res.kind     = KIND_PHOTON;
                    res.channel  = {1'b0, w_chan};
                    res.time_val = time_sum;
                    res.delay    = i_word[24:10];
                end else if (w_chan == WIDE_SPECIAL_OVERFLOW) begin
                    res.kind   = KIND_OVERFLOW;
                    upd.en     = 1'b1;
                    if (i_format == FMT_WIDE_T3_V1) begin
                        res.count  = 25'd1;
                        upd.addend = 64'd1 << WIDE_T3_SHIFT;
                    end else begin
                        res.count  = {15'b0, nsync_count};
                        upd.addend = {{(TimeWidth-10){1'b0}}, nsync_count}
                                     << WIDE_T3_SHIFT;
                    end
                end else if ((w_chan >= 6'd1) && (w_chan <= 6'd15)) begin
                    res.kind     = KIND_MARKER;
                    res.time_val = time_sum;
                    res.marker   = {6'b0, w_chan};
                end else begin
                    res.kind = KIND_IGNORED;
                end
            end
            default: begin
                res.kind = KIND_IGNORED;
            end
        endcase
    end

    assign o_result = res;
    assign o_update = upd;

endmodule

FILE: rtl/tttr_time_tag_record_decoder_core.sv
// ----------------------------------------------------------------------------
// tttr_time_tag_record_decoder_core
// Decodes a stream of 32-bit time-tag records into photon, marker,
// overflow and ignored beats, keeping a running 64-bit overflow base.
//
//   channel   dir  handshake                 payload
//   record    in   i_in_valid / o_in_stall   i_record_word
//   result    out  o_out_valid / i_out_stall o_event_kind .. o_illegal_channel
//   config    in   APB write, pready high    record_format at byte address 0
//
// One beat per cycle sustained while the result side does not stall. A record
// is held in the input register, then decoded, added to the overflow base
// and written to the result register; the base add is the longest path.
// Reset clears the base, the format and both valid flags. A stall on the
// result side holds the result register and backs up into the input register.
// ----------------------------------------------------------------------------
module tttr_time_tag_record_decoder_core import ttd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ApbAddrWidth-1:0]  paddr,
    input  logic [ApbDataWidth-1:0]  pwdata,
    output logic [ApbDataWidth-1:0]  prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [RecordWidth-1:0]   i_record_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_event_kind,
    output logic [ChannelWidth-1:0]  o_channel_number,
    output logic [TimeWidth-1:0]     o_unwrapped_time,
    output logic [DelayWidth-1:0]    o_delay_time,
    output logic [MarkerWidth-1:0]   o_marker_bits,
    output logic [CountWidth-1:0]    o_overflow_count,
    output logic                     o_illegal_channel
);

    logic [FormatWidth-1:0] record_format;
    logic                   r_in_valid;
    logic                   n_in_valid;
    logic [RecordWidth-1:0] r_word;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_result                r_result;
    t_result                dec_result;
    t_base_update           dec_update;
    logic [TimeWidth-1:0]   r_base;
    logic                   in_accept;
    logic                   advance;

    ttd_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_record_format (record_format)
    );

    ttd_record_decode u_decode (
        .i_word   (r_word),
        .i_format (record_format),
        .i_base   (r_base),
        .o_result (dec_result),
        .o_update (dec_update)
    );

    // advance when the result register is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance && dec_update.en) begin
                r_base <= r_base + dec_update.addend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_word <= i_record_word;
        end
        if (advance) begin
            r_result <= dec_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_kind      = r_result.kind;
    assign o_channel_number  = r_result.channel;
    assign o_unwrapped_time  = r_result.time_val;
    assign o_delay_time      = r_result.delay;
    assign o_marker_bits     = r_result.marker;
    assign o_overflow_count  = r_result.count;
    assign o_illegal_channel = r_result.illegal;

endmodule
